[hw/rtl/urtb_pkg.sv]
package urtb_pkg;

	// ring sizes, powers of two
	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 16;
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int TX_AW    = $clog2(TX_DEPTH);

	localparam int BYTE_W = 8;
	localparam int ERR_W  = 3;

	// receive error codes
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'b100;

	typedef enum logic [1:0] {
		CMD_RX_BYTE  = 2'd0,
		CMD_TX_READY = 2'd1,
		CMD_SW_READ  = 2'd2,
		CMD_SW_WRITE = 2'd3
	} cmd_e;

	typedef struct packed {
		cmd_e              command;
		logic [BYTE_W-1:0] byte_in;
		logic              frame_error;
		logic              overrun_error;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_out;
		logic              byte_valid;
		logic [ERR_W-1:0]  error_flags;
		logic              write_accepted;
		logic              tx_event_enabled;
		logic [7:0]        rx_waiting;
	} rsp_t;

endpackage

[hw/rtl/urtb_ram.sv]
module urtb_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/uart_rx_tx_ring_buffers_unit.sv]
// receive and transmit ring buffers between a byte serial port and software
// an accepted transfer passes through stage 1 (ring memory read) and then the output register
// throughput: one item per cycle; each command does at most one ring access, so the
//   input is held off only while stage 1 waits on a stalled output register
// reset: arst_n clears all ring pointers, the last error, the transmit event enable
//   and the pipeline valids; ring memory contents stay unknown until written
module uart_rx_tx_ring_buffers_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  urtb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output urtb_pkg::rsp_t rsp
);
	import urtb_pkg::*;

	// ring pointers: each names the last slot used
	logic [RX_AW-1:0] rx_head_q, rx_tail_q;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q;
	logic [ERR_W-1:0] last_error_q;
	logic             tx_en_q;

	// next-state values worked out for the item being accepted
	logic [RX_AW-1:0] rx_head_d, rx_tail_d;
	logic [TX_AW-1:0] tx_head_d, tx_tail_d;
	logic [ERR_W-1:0] last_error_d;
	logic             tx_en_d;
	logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
	logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;

	// memory ports
	logic             rx_we, rx_re, tx_we, tx_re;
	logic [BYTE_W-1:0] rx_rdata, tx_rdata;

	// per-item flags headed for the result
	logic             byte_valid_d, accepted_d, sel_tx_d;
	logic [RX_AW-1:0] rx_level_d;

	// stage 1: the ring memory read is in flight
	logic             valid_s1;
	logic             byte_valid_s1, accepted_s1, sel_tx_s1, tx_en_s1;
	logic [ERR_W-1:0] err_s1;
	logic [RX_AW-1:0] rx_level_s1;
	logic             s1_advance;
	logic             accept;

	// output register
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	// stage 1 moves on when the output register is empty or being taken
	assign s1_advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	// only one item sits in stage 1; take a new one when it is free or leaving
	assign req_stall  = valid_s1 && !s1_advance;
	assign accept     = req_valid && !req_stall;

	assign rx_head_inc = rx_head_q + RX_AW'(1);
	assign rx_tail_inc = rx_tail_q + RX_AW'(1);
	assign tx_head_inc = tx_head_q + TX_AW'(1);
	assign tx_tail_inc = tx_tail_q + TX_AW'(1);

	// command decode: pointer moves, memory access and flags for the result
	always_comb begin
		rx_head_d    = rx_head_q;
		rx_tail_d    = rx_tail_q;
		tx_head_d    = tx_head_q;
		tx_tail_d    = tx_tail_q;
		last_error_d = last_error_q;
		tx_en_d      = tx_en_q;
		rx_we        = 1'b0;
		rx_re        = 1'b0;
		tx_we        = 1'b0;
		tx_re        = 1'b0;
		byte_valid_d = 1'b0;
		accepted_d   = 1'b0;
		sel_tx_d     = 1'b0;
		unique case (req.command)
			CMD_RX_BYTE: begin
				// full when advancing head would land on tail (one slot kept free)
				if (rx_head_inc == rx_tail_q) begin
					last_error_d = ERR_OVERFLOW;
				end else begin
					last_error_d = {1'b0, req.overrun_error, req.frame_error};
					rx_head_d    = rx_head_inc;
					rx_we        = accept;
				end
			end
			CMD_TX_READY: begin
				sel_tx_d = 1'b1;
				if (tx_head_q != tx_tail_q) begin
					tx_tail_d    = tx_tail_inc;
					tx_re        = accept;
					byte_valid_d = 1'b1;
				end else begin
					// nothing queued: event disables itself
					tx_en_d = 1'b0;
				end
			end
			CMD_SW_READ: begin
				if (rx_head_q != rx_tail_q) begin
					rx_tail_d    = rx_tail_inc;
					rx_re        = accept;
					byte_valid_d = 1'b1;
				end
			end
			CMD_SW_WRITE: begin
				if (tx_head_inc != tx_tail_q) begin
					tx_head_d  = tx_head_inc;
					tx_we      = accept;
					accepted_d = 1'b1;
				end
				// enable stays set even if the byte is dropped, ring holds data
				tx_en_d = 1'b1;
			end
			default: begin
			end
		endcase
		rx_level_d = rx_head_d - rx_tail_d;
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q    <= '0;
			rx_tail_q    <= '0;
			tx_head_q    <= '0;
			tx_tail_q    <= '0;
			last_error_q <= '0;
			tx_en_q      <= 1'b0;
		end else if (accept) begin
			rx_head_q    <= rx_head_d;
			rx_tail_q    <= rx_tail_d;
			tx_head_q    <= tx_head_d;
			tx_tail_q    <= tx_tail_d;
			last_error_q <= last_error_d;
			tx_en_q      <= tx_en_d;
		end
	end

	// writes store at the advanced head, reads load at the advanced tail
	urtb_ram #(
		.Width (BYTE_W),
		.Depth (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_head_inc),
		.wdata (req.byte_in),
		.re    (rx_re),
		.raddr (rx_tail_inc),
		.rdata (rx_rdata)
	);

	urtb_ram #(
		.Width (BYTE_W),
		.Depth (TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_head_inc),
		.wdata (req.byte_in),
		.re    (tx_re),
		.raddr (tx_tail_inc),
		.rdata (tx_rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload; read data stays put while stalled since no new read issues
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_valid_s1 <= byte_valid_d;
			accepted_s1   <= accepted_d;
			sel_tx_s1     <= sel_tx_d;
			tx_en_s1      <= tx_en_d;
			err_s1        <= last_error_d;
			rx_level_s1   <= rx_level_d;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output payload; no-data mark is a zero byte
	always_ff @(posedge clk) begin
		if (s1_advance) begin
			if (!byte_valid_s1) begin
				rsp_q.byte_out <= '0;
			end else if (sel_tx_s1) begin
				rsp_q.byte_out <= tx_rdata;
			end else begin
				rsp_q.byte_out <= rx_rdata;
			end
			rsp_q.byte_valid       <= byte_valid_s1;
			rsp_q.error_flags      <= err_s1;
			rsp_q.write_accepted   <= accepted_s1;
			rsp_q.tx_event_enabled <= tx_en_s1;
			rsp_q.rx_waiting       <= 8'(rx_level_s1);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// one command touches a ring either to write or to read, never both
	a_rx_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_we && rx_re)) else $error("rx ring written and read in one cycle");

	a_tx_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(tx_we && tx_re)) else $error("tx ring written and read in one cycle");

	// a queued byte always leaves the transmit event enabled
	a_write_enables: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.write_accepted |-> rsp.tx_event_enabled)
		else $error("accepted write without transmit event enable");

	// a full stage 1 with a blocked output must hold off new items
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid && rsp_stall |-> req_stall)
		else $error("input taken while pipeline blocked");

endmodule
